// ----- src/bdsr_pkg.sv -----
// ============================================================================
// bdsr_pkg
// Shared types, constants and tables for the boost duty step regulator.
// ============================================================================
package bdsr_pkg;

    // Field widths of the request and result items.
    localparam int LEVEL_W  = 8;
    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 10;
    localparam int VOLT_W   = 15;
    localparam int STEP_W   = 3;

    // Number of brightness levels in the target table, and the ADC resolution.
    localparam int LEVEL_COUNT = 101;
    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_COUNT - 1);

    // Sample mask and the ADC-to-volts scale (3.3 V * 28 * 256).
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam int VSCALE_W = 15;
    localparam logic [VSCALE_W-1:0] VSCALE_Q8 = VSCALE_W'(23654);
    localparam int PROD_W = SAMPLE_W + VSCALE_W;

    // Difference bands in Q8 volts: 5, 4, 3 and 2 V.
    localparam logic [VOLT_W-1:0] BAND_5V = VOLT_W'(1280);
    localparam logic [VOLT_W-1:0] BAND_4V = VOLT_W'(1024);
    localparam logic [VOLT_W-1:0] BAND_3V = VOLT_W'(768);
    localparam logic [VOLT_W-1:0] BAND_2V = VOLT_W'(512);

    // Upper saturation of the duty register.
    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0] CEILING_RESET = DUTY_W'(400);
    localparam logic [DUTY_W-1:0] FLOOR_RESET   = DUTY_W'(1);

    // Command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_DUTY_CEILING = 1'b0,
        REG_DUTY_FLOOR   = 1'b1
    } reg_index_t;

    // Request and result payloads.
    typedef struct packed {
        logic [LEVEL_W-1:0]  brightness_level;
        logic [SAMPLE_W-1:0] feedback_sample;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_compare;
        logic [VOLT_W-1:0] output_volts_q8;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic              step_up;
        logic [STEP_W-1:0] step;
        logic [VOLT_W-1:0] volts;
    } cmd_t;

    // Handshake between a producer and a queue.
    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } q_rd_t;

    // Target voltage table: 0 V at level zero, else 10.0 V + 0.4 V per level.
    typedef logic [LEVEL_COUNT-1:0][VOLT_W-1:0] target_rom_t;

    function automatic target_rom_t build_target_rom();
        target_rom_t rom;
        int lvl;
        for (lvl = 0; lvl < LEVEL_COUNT; lvl++)
        begin
            if (lvl == 0)
                rom[lvl] = '0;
            else
                rom[lvl] = VOLT_W'(2560 + (1024 * lvl + 5) / 10);
        end
        return rom;
    endfunction

    localparam target_rom_t TARGET_ROM = build_target_rom();

    // Step size for a given distance from the target.
    function automatic logic [STEP_W-1:0] band_step(input logic [VOLT_W-1:0] diff);
        logic [STEP_W-1:0] s;
        if (diff > BAND_5V)
            s = STEP_W'(5);
        else if (diff > BAND_4V)
            s = STEP_W'(4);
        else if (diff > BAND_3V)
            s = STEP_W'(3);
        else if (diff > BAND_2V)
            s = STEP_W'(2);
        else
            s = STEP_W'(1);
        return s;
    endfunction

endpackage

// ----- src/bdsr_front.sv -----
// ============================================================================
// bdsr_front
// Front part: accepts requests, looks up the target, scales the sample and
// classifies each request into a step direction and size.
// ============================================================================
module bdsr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  bdsr_pkg::in_item_t sample_item,
    input  logic               push,
    output logic               full,
    output bdsr_pkg::cmd_t     cmd,
    output bdsr_pkg::q_wr_t    cmd_wr,
    input  logic               cmd_full
);

    logic                             st_valid_reg, st_valid_next;
    logic [bdsr_pkg::VOLT_W-1:0]      target_reg, target_next;
    logic [bdsr_pkg::VOLT_W-1:0]      volts_reg, volts_next;
    logic [bdsr_pkg::LEVEL_W-1:0]     level_clamped;
    logic [bdsr_pkg::SAMPLE_W-1:0]    sample_masked;
    logic [bdsr_pkg::PROD_W-1:0]      product;
    logic [bdsr_pkg::VOLT_W-1:0]      diff;
    logic                             accept;
    logic                             cmd_push;
    logic                             below;

    // Accept a new request whenever the stage is free or drains this cycle.
    assign cmd_push = st_valid_reg && !cmd_full;
    assign full     = st_valid_reg && cmd_full;
    assign accept   = push && !full;

    // Clamp the level, look up the target and scale the sample.
    always_comb
    begin
        if (sample_item.brightness_level > bdsr_pkg::LEVEL_MAX)
            level_clamped = bdsr_pkg::LEVEL_MAX;
        else
            level_clamped = sample_item.brightness_level;
        sample_masked = sample_item.feedback_sample & bdsr_pkg::SAMPLE_MASK;
        product       = bdsr_pkg::PROD_W'(sample_masked) * bdsr_pkg::PROD_W'(bdsr_pkg::VSCALE_Q8);
        target_next   = bdsr_pkg::TARGET_ROM[level_clamped[bdsr_pkg::LEVEL_IDX_W-1:0]];
        volts_next    = bdsr_pkg::VOLT_W'(product >> bdsr_pkg::SAMPLE_BITS);
    end

    // Stage valid bit follows loads and drains.
    always_comb
    begin
        if (accept)
            st_valid_next = 1'b1;
        else if (cmd_push)
            st_valid_next = 1'b0;
        else
            st_valid_next = st_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= target_next;
            volts_reg  <= volts_next;
        end
    end

    // Classify the registered request: direction and step size.
    always_comb
    begin
        below = volts_reg < target_reg;
        if (below)
            diff = target_reg - volts_reg;
        else
            diff = volts_reg - target_reg;
        cmd.step_up = below;
        cmd.step    = bdsr_pkg::band_step(diff);
        cmd.volts   = volts_reg;
    end

    assign cmd_wr.push = cmd_push;
    assign cmd_wr.full = cmd_full;

endmodule

// ----- src/bdsr_cmd_queue.sv -----
// ============================================================================
// bdsr_cmd_queue
// Short queue of classified commands between the front and back parts.
// ============================================================================
module bdsr_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  bdsr_pkg::cmd_t  wr_cmd,
    input  bdsr_pkg::q_wr_t wr,
    output logic            full,
    output bdsr_pkg::cmd_t  rd_cmd,
    input  logic            pop,
    output logic            empty
);

    bdsr_pkg::cmd_t                   entry_reg [bdsr_pkg::CMDQ_DEPTH];
    logic [bdsr_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bdsr_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bdsr_pkg::CMDQ_CNT_W-1:0]  count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = count_reg == bdsr_pkg::CMDQ_CNT_W'(bdsr_pkg::CMDQ_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = wr.push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdsr_pkg::CMDQ_CNT_W'(bdsr_pkg::CMDQ_DEPTH))
        else $error("command queue count exceeds depth");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr.push)
        else $error("push into full command queue");

    // Pointer distance always matches the fill count.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == bdsr_pkg::CMDQ_CNT_W'(bdsr_pkg::CMDQ_DEPTH)) ||
        (bdsr_pkg::CMDQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) ==
         count_reg[bdsr_pkg::CMDQ_PTR_W-1:0]))
        else $error("command queue pointers disagree with count");

endmodule

// ----- src/bdsr_back.sv -----
// ============================================================================
// bdsr_back
// Back part: applies each command to the duty register and queues results.
// ============================================================================
module bdsr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bdsr_pkg::cmd_t               cmd,
    output bdsr_pkg::q_rd_t              cmd_rd,
    input  logic                         cmd_empty,
    input  logic [bdsr_pkg::DUTY_W-1:0]  duty_ceiling,
    input  logic [bdsr_pkg::DUTY_W-1:0]  duty_floor,
    output bdsr_pkg::out_item_t          result_item,
    output logic                         empty,
    input  logic                         pop
);

    logic [bdsr_pkg::DUTY_W-1:0]  duty_reg, duty_next;
    logic [bdsr_pkg::DUTY_W:0]    duty_sum;
    bdsr_pkg::out_item_t          res_reg [2];
    logic                         wr_ptr_reg, wr_ptr_next;
    logic                         rd_ptr_reg, rd_ptr_next;
    logic [1:0]                   count_reg, count_next;
    logic                         res_full;
    logic                         take;
    logic                         give;
    bdsr_pkg::out_item_t          res_new;

    assign res_full = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign take     = !cmd_empty && !res_full;
    assign give     = pop && !empty;

    assign cmd_rd.pop   = take;
    assign cmd_rd.empty = cmd_empty;

    // Duty step: up toward the ceiling, down toward the floor.
    always_comb
    begin
        duty_sum = {1'b0, duty_reg} + (bdsr_pkg::DUTY_W + 1)'(cmd.step);
        if (cmd.step_up)
        begin
            if (duty_reg > duty_ceiling)
                duty_next = duty_ceiling;
            else if (duty_sum > {1'b0, bdsr_pkg::DUTY_MAX})
                duty_next = bdsr_pkg::DUTY_MAX;
            else
                duty_next = duty_sum[bdsr_pkg::DUTY_W-1:0];
        end
        else
        begin
            if (duty_reg < bdsr_pkg::DUTY_W'(cmd.step) + bdsr_pkg::DUTY_W'(1))
                duty_next = duty_floor;
            else
                duty_next = duty_reg - bdsr_pkg::DUTY_W'(cmd.step);
        end
        res_new.duty_compare    = duty_next;
        res_new.output_volts_q8 = cmd.volts;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= '0;
        else if (take)
            duty_reg <= duty_next;
    end

    // Result queue pointers and count.
    always_comb
    begin
        wr_ptr_next = take ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = give ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (take && !give)
            count_next = count_reg + 2'd1;
        else if (give && !take)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg[wr_ptr_reg] <= res_new;
    end

    assign result_item = res_reg[rd_ptr_reg];

endmodule

// ----- src/boost_duty_step_regulator.sv -----
// ============================================================================
// boost_duty_step_regulator
// Boost converter duty regulator: one duty step per feedback sample.
// ============================================================================
// Takes one request per clock while full is low: a brightness level and a
// feedback ADC sample. The result (new duty compare value and measured
// output volts in Q8) passes through the lookup and scaling register, the
// command queue and the result queue before it can be popped. Sustained
// rate is one request per cycle while results are popped as they arrive;
// the duty register in the back part takes one step per command. The
// four-entry command queue and the two-entry result queue absorb stalls on
// the result side; full rises only when both are backed up. Registers
// duty_ceiling (byte address 0) and duty_floor (byte address 4) should be
// written only while no request is in flight.
// ============================================================================
module boost_duty_step_regulator (
    input  logic                clk,
    input  logic                rst_n,
    // Request side
    input  bdsr_pkg::in_item_t  sample_item,
    input  logic                push,
    output logic                full,
    // Result side
    output bdsr_pkg::out_item_t result_item,
    output logic                empty,
    input  logic                pop,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [bdsr_pkg::DUTY_W-1:0] ceiling_reg, ceiling_next;
    logic [bdsr_pkg::DUTY_W-1:0] floor_reg, floor_next;
    bdsr_pkg::reg_index_t        reg_sel;
    logic                        cfg_write;
    bdsr_pkg::cmd_t              front_cmd;
    bdsr_pkg::cmd_t              queue_cmd;
    bdsr_pkg::q_wr_t             cmd_wr;
    bdsr_pkg::q_rd_t             cmd_rd;
    logic                        cmd_full;
    logic                        cmd_empty;

    // Configuration register decode.
    assign pready    = 1'b1;
    assign reg_sel   = bdsr_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        ceiling_next = ceiling_reg;
        floor_next   = floor_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                bdsr_pkg::REG_DUTY_CEILING: ceiling_next = pwdata[bdsr_pkg::DUTY_W-1:0];
                bdsr_pkg::REG_DUTY_FLOOR:   floor_next   = pwdata[bdsr_pkg::DUTY_W-1:0];
                default:                    ceiling_next = ceiling_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= bdsr_pkg::CEILING_RESET;
            floor_reg   <= bdsr_pkg::FLOOR_RESET;
        end
        else
        begin
            ceiling_reg <= ceiling_next;
            floor_reg   <= floor_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_sel)
            bdsr_pkg::REG_DUTY_CEILING: prdata = 32'(ceiling_reg);
            bdsr_pkg::REG_DUTY_FLOOR:   prdata = 32'(floor_reg);
            default:                    prdata = '0;
        endcase
    end

    // Front part: lookup, scaling and classification.
    bdsr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_item (sample_item),
        .push        (push),
        .full        (full),
        .cmd         (front_cmd),
        .cmd_wr      (cmd_wr),
        .cmd_full    (cmd_full)
    );

    // Command queue between the two parts.
    bdsr_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cmd (front_cmd),
        .wr     (cmd_wr),
        .full   (cmd_full),
        .rd_cmd (queue_cmd),
        .pop    (cmd_rd.pop),
        .empty  (cmd_empty)
    );

    // Back part: duty update and result queue.
    bdsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (queue_cmd),
        .cmd_rd       (cmd_rd),
        .cmd_empty    (cmd_empty),
        .duty_ceiling (ceiling_reg),
        .duty_floor   (floor_reg),
        .result_item  (result_item),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
